FILE: sv/bbr_pkg.sv
package bbr_pkg;

   localparam int BufferBits  = 64;
   localparam int MaxReadBits = 32;
   localparam int FillWidth   = $clog2(BufferBits + 1);
   localparam int CountWidth  = 6;
   localparam int ByteWidth   = 8;
   localparam int SkipWidth   = 4;
   localparam int WindowBits  = MaxReadBits + ByteWidth;

   localparam logic [ByteWidth-1:0] StuffByte = 8'h7f;

   typedef enum logic [2:0] {
      OP_PUSH  = 3'd0,
      OP_GET   = 3'd1,
      OP_SHOW  = 3'd2,
      OP_SKIP  = 3'd3,
      OP_APEEK = 3'd4,
      OP_QUERY = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_UNDERFLOW = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   typedef struct packed {
      logic [FillWidth-1:0]   fill_after;
      logic                   aligned;
      status_type             status;
      logic [MaxReadBits-1:0] bits;
   } result_type;

endpackage

FILE: sv/bbr_exec.sv
// One request against the bit buffer. The buffer is kept left-justified:
// the oldest bit sits at the top, and bits below the fill level are zero.
module bbr_exec (
   input  logic [2:0]                         op,
   input  logic [bbr_pkg::ByteWidth-1:0]      byte_in,
   input  logic [bbr_pkg::CountWidth-1:0]     count,
   input  logic [bbr_pkg::BufferBits-1:0]     store,
   input  logic [bbr_pkg::FillWidth-1:0]      fill,
   output logic [bbr_pkg::BufferBits-1:0]     store_next,
   output logic [bbr_pkg::FillWidth-1:0]      fill_next,
   output bbr_pkg::result_type                result
);

   logic [bbr_pkg::CountWidth-1:0]  cnt;
   logic [bbr_pkg::FillWidth-1:0]   cnt_ext;
   logic [bbr_pkg::SkipWidth-1:0]   skip;
   logic [bbr_pkg::FillWidth-1:0]   skip_need;
   logic [bbr_pkg::WindowBits-1:0]  window;
   logic [bbr_pkg::WindowBits-1:0]  window_sh;
   logic [bbr_pkg::MaxReadBits-1:0] top_bits;
   logic [bbr_pkg::CountWidth-1:0]  rjust;
   logic [bbr_pkg::MaxReadBits-1:0] peek_val;
   logic [bbr_pkg::BufferBits-1:0]  push_word;
   logic [2:0]                      align_sum;

   always_comb begin
      if (count > bbr_pkg::CountWidth'(bbr_pkg::MaxReadBits)) begin
         cnt = bbr_pkg::CountWidth'(bbr_pkg::MaxReadBits);
      end else begin
         cnt = count;
      end
   end

   assign cnt_ext = bbr_pkg::FillWidth'(cnt);

   // bits left in the current byte, or a whole stuffing byte when aligned
   always_comb begin
      skip = bbr_pkg::SkipWidth'(fill[2:0]);
      if (fill[2:0] == 3'd0 &&
          store[bbr_pkg::BufferBits-1 -: bbr_pkg::ByteWidth] == bbr_pkg::StuffByte) begin
         skip = bbr_pkg::SkipWidth'(bbr_pkg::ByteWidth);
      end
   end

   assign skip_need = bbr_pkg::FillWidth'(skip) + cnt_ext;

   // shared barrel shifter: offset is 0 except for the aligned peek
   assign window    = store[bbr_pkg::BufferBits-1 -: bbr_pkg::WindowBits];
   assign window_sh = (op == bbr_pkg::OP_APEEK) ? (window << skip) : window;
   assign top_bits  = window_sh[bbr_pkg::WindowBits-1 -: bbr_pkg::MaxReadBits];
   assign rjust     = bbr_pkg::CountWidth'(bbr_pkg::MaxReadBits) - cnt;
   assign peek_val  = top_bits >> rjust;

   assign push_word = {byte_in, {(bbr_pkg::BufferBits - bbr_pkg::ByteWidth){1'b0}}} >> fill;
   assign align_sum = fill[2:0] + count[2:0];

   always_comb begin
      store_next        = store;
      fill_next         = fill;
      result.bits       = '0;
      result.status     = bbr_pkg::STATUS_OK;
      result.aligned    = 1'b0;
      unique case (op)
         bbr_pkg::OP_PUSH: begin
            if (fill > bbr_pkg::FillWidth'(bbr_pkg::BufferBits - bbr_pkg::ByteWidth)) begin
               result.status = bbr_pkg::STATUS_FULL;
            end else begin
               store_next = store | push_word;
               fill_next  = fill + bbr_pkg::FillWidth'(bbr_pkg::ByteWidth);
            end
         end
         bbr_pkg::OP_GET, bbr_pkg::OP_SHOW, bbr_pkg::OP_SKIP: begin
            if (cnt != '0) begin
               if (cnt_ext > fill) begin
                  result.status = bbr_pkg::STATUS_UNDERFLOW;
               end else begin
                  if (op != bbr_pkg::OP_SKIP) begin
                     result.bits = peek_val;
                  end
                  if (op != bbr_pkg::OP_SHOW) begin
                     store_next = store << cnt;
                     fill_next  = fill - cnt_ext;
                  end
               end
            end
         end
         bbr_pkg::OP_APEEK: begin
            if (cnt != '0) begin
               if (fill[2:0] == 3'd0 &&
                   fill < bbr_pkg::FillWidth'(bbr_pkg::ByteWidth)) begin
                  result.status = bbr_pkg::STATUS_UNDERFLOW;
               end else if (skip_need > fill) begin
                  result.status = bbr_pkg::STATUS_UNDERFLOW;
               end else begin
                  result.bits = peek_val;
               end
            end
         end
         bbr_pkg::OP_QUERY: begin
            result.aligned = (align_sum == 3'd0);
         end
         default: begin
         end
      endcase
      result.fill_after = fill_next;
   end

endmodule

FILE: sv/bitstream_bit_reader.sv
// MSB-first bit reader over a 64-bit buffer. Push appends a byte; get, show,
// skip and aligned peek each read up to 32 bits from the front through one
// barrel shifter, and aligned query reports whether fill plus count is byte
// aligned. One word is accepted every cycle while the result side does not
// stall, and each gives exactly one result word (request register, then
// result register); the buffer and fill level update in the cycle the request
// leaves the request register, so back-to-back requests see each other's
// effects. An underflow or a push into a full buffer reports its status and leaves the buffer unchanged.
module bitstream_bit_reader (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // byte_in[7:0], count[13:8], zero pad
   input  logic [2:0]  req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // bits[31:0], status[33:32], aligned[34],
                                    // fill_after[41:35], zero pad
);

   logic                                s1_valid_ff, s1_valid_in;
   logic [2:0]                          s1_op_ff;
   logic [bbr_pkg::ByteWidth-1:0]       s1_byte_ff;
   logic [bbr_pkg::CountWidth-1:0]      s1_count_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   bbr_pkg::result_type                 rsp_data_ff;
   logic [bbr_pkg::BufferBits-1:0]      store_ff, store_in;
   logic [bbr_pkg::FillWidth-1:0]       fill_ff, fill_in;
   bbr_pkg::result_type                 result;
   logic                                advance;
   logic                                req_take;

   assign advance  = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_take = req_tvalid && req_tready;

   assign req_tready = !s1_valid_ff || advance;

   bbr_exec u_exec (
      .op         (s1_op_ff),
      .byte_in    (s1_byte_ff),
      .count      (s1_count_ff),
      .store      (store_ff),
      .fill       (fill_ff),
      .store_next (store_in),
      .fill_next  (fill_in),
      .result     (result)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         store_ff     <= '0;
         fill_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            store_ff <= store_in;
            fill_ff  <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff    <= req_tuser;
         s1_byte_ff  <= req_tdata[7:0];
         s1_count_ff <= req_tdata[13:8];
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_data_ff};

endmodule

FILE: tb/tb_top.sv
module tb_top;
   import bbr_pkg::*;

   localparam logic [2:0] OpSpare6 = 3'd6;
   localparam logic [2:0] OpSpare7 = 3'd7;
   localparam int CycleLimit = 200000;
   localparam int DrainCycles = 20;
   localparam int HoldCycles = 250;
   localparam int PhaseWords = 125;
   localparam int ReportLimit = 10;

   typedef struct packed {
      logic [2:0]           op;
      logic [ByteWidth-1:0] byte_in;
      logic [5:0]           count;
      logic                 fixed;
      result_type           exp;
   } dir_row_type;

   localparam result_type Predicted = '0;
   localparam int NumRows = 26;

   // Bytes pushed: FF 00 7F 80 A5 5A 3C C3, then one more into a full buffer.
   localparam dir_row_type DirRows [NumRows] = '{
      '{OP_GET,   8'h00, 6'd1,  1'b1, '{7'd0,  1'b0, STATUS_UNDERFLOW, 32'd0}},
      '{OP_APEEK, 8'h00, 6'd4,  1'b1, '{7'd0,  1'b0, STATUS_UNDERFLOW, 32'd0}},
      '{OP_QUERY, 8'h00, 6'd0,  1'b1, '{7'd0,  1'b1, STATUS_OK,        32'd0}},
      '{OP_QUERY, 8'h00, 6'd3,  1'b1, '{7'd0,  1'b0, STATUS_OK,        32'd0}},
      '{OP_PUSH,  8'hff, 6'd0,  1'b1, '{7'd8,  1'b0, STATUS_OK,        32'd0}},
      '{OP_PUSH,  8'h00, 6'd63, 1'b0, Predicted},
      '{OP_PUSH,  8'h7f, 6'd0,  1'b0, Predicted},
      '{OP_PUSH,  8'h80, 6'd0,  1'b0, Predicted},
      '{OP_PUSH,  8'ha5, 6'd0,  1'b0, Predicted},
      '{OP_PUSH,  8'h5a, 6'd0,  1'b0, Predicted},
      '{OP_PUSH,  8'h3c, 6'd0,  1'b0, Predicted},
      '{OP_PUSH,  8'hc3, 6'd0,  1'b1, '{7'd64, 1'b0, STATUS_OK,        32'd0}},
      '{OP_PUSH,  8'h12, 6'd0,  1'b1, '{7'd64, 1'b0, STATUS_FULL,      32'd0}},
      '{OP_GET,   8'h00, 6'd0,  1'b1, '{7'd64, 1'b0, STATUS_OK,        32'd0}},
      '{OP_SHOW,  8'h00, 6'd63, 1'b1, '{7'd64, 1'b0, STATUS_OK,  32'hff007f80}},
      '{OP_GET,   8'h00, 6'd8,  1'b1, '{7'd56, 1'b0, STATUS_OK,  32'h000000ff}},
      '{OP_GET,   8'h00, 6'd8,  1'b1, '{7'd48, 1'b0, STATUS_OK,        32'd0}},
      '{OP_APEEK, 8'h00, 6'd8,  1'b0, Predicted},
      '{OP_GET,   8'h00, 6'd3,  1'b0, Predicted},
      '{OP_QUERY, 8'h00, 6'd5,  1'b0, Predicted},
      '{OP_APEEK, 8'h00, 6'd12, 1'b0, Predicted},
      '{OP_SKIP,  8'h00, 6'd40, 1'b0, Predicted},
      '{OP_GET,   8'h00, 6'd32, 1'b0, Predicted},
      '{OpSpare6, 8'hff, 6'd63, 1'b0, Predicted},
      '{OpSpare7, 8'h55, 6'd9,  1'b0, Predicted},
      '{OP_SHOW,  8'h00, 6'd0,  1'b0, Predicted}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;

   bitstream_bit_reader dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // reader state mirror
   logic [ByteWidth-1:0] ring_bytes [BufferBits/8];
   int unsigned head_bit;
   int unsigned fill_bits;

   result_type pending_results [$];
   int error_count = 0;
   int report_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_requests = 0;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic [31:0] peek_front(int unsigned offset, int unsigned n);
      logic [31:0] v;
      int unsigned p;
      v = '0;
      for (int unsigned i = 0; i < n; i++) begin
         p = (head_bit + offset + i) % BufferBits;
         v = {v[30:0], ring_bytes[p >> 3][7 - (p % 8)]};
      end
      return v;
   endfunction

   function automatic result_type next_reader_result(logic [2:0] op, logic [7:0] b,
                                                     logic [5:0] raw);
      result_type r;
      int unsigned cnt;
      int unsigned skip;
      r = '0;
      cnt = (raw > MaxReadBits) ? MaxReadBits : raw;
      case (op)
         OP_PUSH: begin
            if (fill_bits + 8 > BufferBits) begin
               r.status = STATUS_FULL;
            end else begin
               ring_bytes[((head_bit + fill_bits) % BufferBits) >> 3] = b;
               fill_bits += 8;
            end
         end
         OP_GET, OP_SHOW, OP_SKIP: begin
            if (cnt != 0) begin
               if (cnt > fill_bits) begin
                  r.status = STATUS_UNDERFLOW;
               end else begin
                  if (op != OP_SKIP) r.bits = peek_front(0, cnt);
                  if (op != OP_SHOW) begin
                     head_bit = (head_bit + cnt) % BufferBits;
                     fill_bits -= cnt;
                  end
               end
            end
         end
         OP_APEEK: begin
            if (cnt != 0) begin
               skip = fill_bits % 8;
               // aligned: a whole stuffing byte at the front is stepped over
               if (skip == 0 && fill_bits < 8) begin
                  r.status = STATUS_UNDERFLOW;
               end else begin
                  if (skip == 0 && peek_front(0, 8) == StuffByte) skip = 8;
                  if (skip + cnt > fill_bits) r.status = STATUS_UNDERFLOW;
                  else r.bits = peek_front(skip, cnt);
               end
            end
         end
         OP_QUERY: r.aligned = (((fill_bits % 8) + raw) % 8) == 0;
         default: ;
      endcase
      r.fill_after = 7'(fill_bits);
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_word(logic [2:0] op, logic [7:0] b, logic [5:0] cnt,
                            logic fixed, result_type fixed_exp);
      result_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, cnt, b};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      r = next_reader_result(op, b, cnt);
      pending_results.push_back(fixed ? fixed_exp : r);
      @(negedge clock);
   endtask

   // receiver: random stalls plus long hold-offs on request
   initial begin
      int hold_seen;
      int hold_left;
      int stall_pct;
      hold_seen = 0;
      hold_left = 0;
      stall_pct = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         stall_pct = recv_stall_pct;
         if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HoldCycles;
         end
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata[$bits(result_type)-1:0]);
         if (pending_results.size() == 0) begin
            error_count++;
            if (report_count < ReportLimit) begin
               report_count++;
               $display("unexpected result word %h", rsp_tdata);
            end
         end else begin
            want = pending_results.pop_front();
            if (got.bits !== want.bits || got.status !== want.status ||
                got.aligned !== want.aligned || got.fill_after !== want.fill_after) begin
               error_count++;
               if (report_count < ReportLimit) begin
                  report_count++;
                  $display("mismatch: bits %h/%h status %0d/%0d aligned %0d/%0d fill %0d/%0d",
                           want.bits, got.bits, want.status, got.status,
                           want.aligned, got.aligned, want.fill_after, got.fill_after);
               end
            end
         end
      end
   end

   initial begin
      logic [2:0] op;
      logic [7:0] b;
      logic [5:0] cnt;
      int r;
      int issued;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      head_bit = 0;
      fill_bits = 0;
      for (int i = 0; i < BufferBits/8; i++) ring_bytes[i] = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < NumRows; i++)
         send_word(DirRows[i].op, DirRows[i].byte_in, DirRows[i].count,
                   DirRows[i].fixed, DirRows[i].exp);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default: begin send_idle_pct = 9; recv_stall_pct = 9; end
         endcase
         // long hold-off with a busy sender backs the block up to its input
         if (phase == 0) hold_requests++;
         issued = 0;
         while (issued < PhaseWords) begin
            r = $urandom_range(99);
            b = (($urandom_range(5) == 0) ? StuffByte : 8'($urandom_range(255)));
            if ($urandom_range(19) == 0) cnt = 6'($urandom_range(63));
            else if ($urandom_range(19) == 0) cnt = '0;
            else cnt = 6'($urandom_range(12, 1));
            if ($urandom_range(4) == 0) cnt = 6'($urandom_range(63));
            // keep the fill level wandering over its whole range
            if (r < 2) begin
               op = r[0] ? OpSpare7 : OpSpare6;
            end else if (r < ((fill_bits < 24) ? 60 : (fill_bits > 48) ? 15 : 38)) begin
               op = OP_PUSH;
            end else begin
               case ($urandom_range(4))
                  0: op = OP_GET;
                  1: op = OP_SHOW;
                  2: op = OP_SKIP;
                  3: op = OP_APEEK;
                  default: op = OP_QUERY;
               endcase
            end
            send_word(op, b, cnt, 1'b0, Predicted);
            if (op <= OP_QUERY) issued++;
         end
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
